>>> sv/calendar_datetime_seconds_adder_macros.svh
// Assertion macros for the calendar date/time seconds adder.
// Included by the top level; no other dependencies.
`ifndef CALENDAR_DATETIME_SECONDS_ADDER_MACROS_SVH
`define CALENDAR_DATETIME_SECONDS_ADDER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CDSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CDSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/cdsa_pkg.sv
// Shared widths, constants, types and calendar functions for the
// calendar date/time seconds adder. No dependencies.
package cdsa_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int ADD_W     = 31;
    localparam int DVD_W     = 32;
    localparam int DAYCNT_W  = 15;

    localparam logic [MIN_W-1:0] SEC_PER_MIN  = 6'd60;
    localparam logic [MIN_W-1:0] HOUR_PER_DAY = 6'd24;

    // x/60 is (x >> 2)/15 and x/24 is (x >> 3)/3; both reciprocals are exact for 32-bit x
    localparam logic [DVD_W-1:0] RECIP_15   = 32'h8888_8889;
    localparam logic [DVD_W-1:0] RECIP_3    = 32'hAAAA_AAAB;
    localparam int               PRE_SH_60  = 2;
    localparam int               PRE_SH_24  = 3;
    localparam int               POST_SH_15 = 35;
    localparam int               POST_SH_3  = 33;

    localparam logic [MONTH_W:0] MONTHS_PER_YEAR = 5'd12;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;

    // multiplicative inverse of 25 modulo 2^14 and the divisibility bound
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    // divisor select codes
    localparam logic DIV_BY_60 = 1'b0;
    localparam logic DIV_BY_24 = 1'b1;

    typedef struct packed {
        logic             start;
        logic             sel;
        logic [DVD_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [MIN_W-1:0] rem;
    } div_rsp_t;

    // y % 400 == 0 is y % 16 == 0 and y % 25 == 0; y % 100 == 0 is y % 4 and y % 25
    function automatic logic cdsa_is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              by25;
        begin
            prod = y * INV25;
            by25 = (prod <= DIV25_LIMIT);
            return ((y[1:0] == 2'd0) && !by25) || ((y[3:0] == 4'd0) && by25);
        end
    endfunction

    function automatic logic [DAY_W-1:0] cdsa_month_len(input logic [YEAR_W-1:0]  y,
                                                        input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                    len = DAYS_31;
                MON_APR, MON_JUN, MON_SEP, MON_NOV:
                    len = DAYS_30;
                MON_FEB:
                    len = cdsa_is_leap(y) ? DAYS_29 : DAYS_28;
                default:
                    len = DAYS_30;
            endcase
            return len;
        end
    endfunction

endpackage

>>> sv/cdsa_if.sv
// Valid/ready channel interfaces for the calendar date/time seconds adder.
// Depends on cdsa_pkg for field widths.
interface cdsa_in_if import cdsa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    start_year;
    logic [MONTH_W-1:0]   start_month;
    logic [DAY_W-1:0]     start_day;
    logic [HOUR_W-1:0]    start_hour;
    logic [MIN_W-1:0]     start_minute;
    logic [SEC_W-1:0]     start_second;
    logic [ADD_W-1:0]     seconds_to_add;

    modport source (
        output valid, start_year, start_month, start_day, start_hour,
               start_minute, start_second, seconds_to_add,
        input  ready
    );

    modport sink (
        input  valid, start_year, start_month, start_day, start_hour,
               start_minute, start_second, seconds_to_add,
        output ready
    );
endinterface

interface cdsa_out_if import cdsa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    result_year;
    logic [MONTH_W-1:0]   result_month;
    logic [DAY_W-1:0]     result_day;
    logic [HOUR_W-1:0]    result_hour;
    logic [MIN_W-1:0]     result_minute;
    logic [SEC_W-1:0]     result_second;

    modport source (
        output valid, result_year, result_month, result_day, result_hour,
               result_minute, result_second,
        input  ready
    );

    modport sink (
        input  valid, result_year, result_month, result_day, result_hour,
               result_minute, result_second,
        output ready
    );
endinterface

>>> sv/cdsa_div.sv
// Shared divider by 60 or by 24: pre-shift, multiply by a fixed reciprocal,
// then rebuild the remainder; a new request is taken only while not busy. Depends on cdsa_pkg.
module cdsa_div import cdsa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 mul_reg, mul_next;
    logic                 done_reg, done_next;
    logic                 sel_reg, sel_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [2*DVD_W-1:0]   prod_reg, prod_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [MIN_W-1:0]     rem_reg, rem_next;

    logic [DVD_W-1:0]     mul_op;
    logic [DVD_W-1:0]     recip;
    logic [DVD_W-1:0]     quo_calc;
    logic [MIN_W-1:0]     q_low;
    logic [MIN_W-1:0]     qd_low;

    assign mul_op   = (sel_reg == DIV_BY_24) ? (dvd_reg >> PRE_SH_24) : (dvd_reg >> PRE_SH_60);
    assign recip    = (sel_reg == DIV_BY_24) ? RECIP_3 : RECIP_15;
    assign quo_calc = (sel_reg == DIV_BY_24) ? DVD_W'(prod_reg >> POST_SH_3)
                                             : DVD_W'(prod_reg >> POST_SH_15);

    // the remainder is below 64, so the low six bits of x - q*d are enough
    assign q_low  = quo_calc[MIN_W-1:0];
    assign qd_low = (sel_reg == DIV_BY_24) ? ((q_low << 4) + (q_low << 3)) : -(q_low << 2);

    always_comb
    begin
        busy_next = busy_reg;
        mul_next  = mul_reg;
        done_next = 1'b0;
        sel_next  = sel_reg;
        dvd_next  = dvd_reg;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (busy_reg && !mul_reg)
        begin
            prod_next = (2*DVD_W)'(mul_op) * (2*DVD_W)'(recip);
            mul_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = quo_calc;
            rem_next  = dvd_reg[MIN_W-1:0] - qd_low;
            busy_next = 1'b0;
            mul_next  = 1'b0;
            done_next = 1'b1;
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            sel_next  = req.sel;
            dvd_next  = req.dividend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        dvd_reg  <= dvd_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> sv/calendar_datetime_seconds_adder.sv
// Top level of the calendar date/time seconds adder: sequencer, calendar
// registers and output register. Depends on cdsa_pkg, cdsa_if, cdsa_div, macros.
//
//   channel  modport             beat
//   req      cdsa_in_if.sink     start date/time and seconds to add
//   rsp      cdsa_out_if.source  resulting date/time
//
// One beat takes three passes through the shared divider (seconds, minutes,
// hours), one month step per month end crossed plus one more, and a final
// step that loads the output register; up to about 820 month ends are crossed
// for the largest offset. req.ready is high only while no beat is in work; a
// result beat not yet taken holds the block in its last step.
// Reset clears the sequencer and the output valid.
`include "calendar_datetime_seconds_adder_macros.svh"

module calendar_datetime_seconds_adder import cdsa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cdsa_in_if.sink   req,
    cdsa_out_if.source rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_MONTH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] PH_SEC  = 2'd0;
    localparam logic [1:0] PH_MIN  = 2'd1;
    localparam logic [1:0] PH_HOUR = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAYCNT_W-1:0] day_reg, day_next;
    logic [HOUR_W-1:0]   hour_start_reg, hour_start_next;
    logic [MIN_W-1:0]    min_start_reg, min_start_next;
    logic [SEC_W-1:0]    sec_res_reg, sec_res_next;
    logic [MIN_W-1:0]    min_res_reg, min_res_next;
    logic [HOUR_W-1:0]   hour_res_reg, hour_res_next;

    logic                out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]   out_year_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [DAY_W-1:0]    out_day_reg;
    logic [HOUR_W-1:0]   out_hour_reg;
    logic [MIN_W-1:0]    out_min_reg;
    logic [SEC_W-1:0]    out_sec_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [DAY_W-1:0]    dim;
    logic                day_over;
    logic [MONTH_W:0]    month_inc;
    logic                out_load;

    cdsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign dim       = cdsa_month_len(year_reg, month_reg);
    assign day_over  = (day_reg > {{(DAYCNT_W-DAY_W){1'b0}}, dim});
    assign month_inc = {1'b0, month_reg} + 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        hour_start_next = hour_start_reg;
        min_start_next  = min_start_reg;
        sec_res_next    = sec_res_reg;
        min_res_next    = min_res_reg;
        hour_res_next   = hour_res_reg;
        div_req.start    = 1'b0;
        div_req.sel      = DIV_BY_60;
        div_req.dividend = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    year_next       = req.start_year;
                    month_next      = req.start_month;
                    day_next        = DAYCNT_W'(req.start_day);
                    hour_start_next = req.start_hour;
                    min_start_next  = req.start_minute;
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(req.start_second) + DVD_W'(req.seconds_to_add);
                    phase_next      = PH_SEC;
                    state_next      = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    case (phase_reg)
                        PH_SEC:
                        begin
                            sec_res_next     = div_rsp.rem;
                            div_req.start    = 1'b1;
                            div_req.dividend = DVD_W'(min_start_reg) + div_rsp.quot;
                            phase_next       = PH_MIN;
                        end
                        PH_MIN:
                        begin
                            min_res_next     = div_rsp.rem;
                            div_req.start    = 1'b1;
                            div_req.sel      = DIV_BY_24;
                            div_req.dividend = DVD_W'(hour_start_reg) + div_rsp.quot;
                            phase_next       = PH_HOUR;
                        end
                        default:
                        begin
                            hour_res_next = div_rsp.rem[HOUR_W-1:0];
                            day_next      = day_reg + div_rsp.quot[DAYCNT_W-1:0];
                            state_next    = ST_MONTH;
                        end
                    endcase
                end
            end
            ST_MONTH:
            begin
                if (day_over)
                begin
                    // advance one month; past December wraps into next year
                    day_next = day_reg - DAYCNT_W'(dim);
                    if (month_inc > MONTHS_PER_YEAR)
                    begin
                        month_next = MON_JAN;
                        year_next  = year_reg + 1'b1;
                    end
                    else
                    begin
                        month_next = month_inc[MONTH_W-1:0];
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_SEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg       <= year_next;
        month_reg      <= month_next;
        day_reg        <= day_next;
        hour_start_reg <= hour_start_next;
        min_start_reg  <= min_start_next;
        sec_res_reg    <= sec_res_next;
        min_res_reg    <= min_res_next;
        hour_res_reg   <= hour_res_next;
        if (out_load)
        begin
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg;
            out_day_reg   <= day_reg[DAY_W-1:0];
            out_hour_reg  <= hour_res_reg;
            out_min_reg   <= min_res_reg;
            out_sec_reg   <= sec_res_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_year   = out_year_reg;
    assign rsp.result_month  = out_month_reg;
    assign rsp.result_day    = out_day_reg;
    assign rsp.result_hour   = out_hour_reg;
    assign rsp.result_minute = out_min_reg;
    assign rsp.result_second = out_sec_reg;

    `CDSA_ASSERT_IMPL(a_idle_div_quiet, clk, rst_n, state_reg == ST_IDLE,
                      !div_rsp.busy && !div_rsp.done, "divider active while idle")
    `CDSA_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_rsp.done, state_reg == ST_DIV,
                      "divider finished outside the divide phase")
    `CDSA_ASSERT_NEXT(a_month_shrinks, clk, rst_n, state_reg == ST_MONTH && day_over,
                      day_reg < $past(day_reg), "month rollover did not reduce the day count")
    `CDSA_ASSERT_NEXT(a_load_to_idle, clk, rst_n, out_load,
                      rsp.valid && state_reg == ST_IDLE, "result load did not present a beat")

endmodule

>>> test/tb.sv
// Self-checking bench for calendar_datetime_seconds_adder: directed and random
// timestamps with random offsets, checked against an in-bench calendar model.
// Depends on cdsa_pkg, cdsa_if and the RTL top level.
module tb import cdsa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } stamp_t;

    typedef struct {
        stamp_t            start;
        logic [ADD_W-1:0]  offset;
        int                gap;
        bit                drain_first;
    } add_beat_t;

    logic clk;
    logic rst_n;

    cdsa_in_if  req_ch ();
    cdsa_out_if rsp_ch ();

    calendar_datetime_seconds_adder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    add_beat_t pending_beats[$];
    stamp_t    results_due[$];
    add_beat_t cur_beat;
    int        hold_left;
    bit        gap_drawn;
    int        stall_left;
    int        results_seen;
    int        mismatches;
    int        beats_queued;

    function automatic bit year_is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W:0]  m);
        int unsigned len;
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                len = DAYS_31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:
                len = DAYS_30;
            MON_FEB:
                len = year_is_leap(y) ? DAYS_29 : DAYS_28;
            default:
                len = DAYS_30;
        endcase
        return len;
    endfunction

    function automatic stamp_t advance_stamp(input add_beat_t b);
        longint unsigned   secs;
        longint unsigned   mins;
        longint unsigned   hrs;
        longint unsigned   days;
        logic [YEAR_W-1:0] y;
        logic [MONTH_W:0]  m;
        stamp_t            adv;
        secs = longint'(b.start.second) + longint'(b.offset);
        mins = longint'(b.start.minute) + secs / SEC_PER_MIN;
        hrs  = longint'(b.start.hour) + mins / SEC_PER_MIN;
        days = longint'(b.start.day) + hrs / HOUR_PER_DAY;
        y    = b.start.year;
        m    = {1'b0, b.start.month};
        // roll one month at a time; a month past 12 (even 13..15) wraps to January
        while (days > month_days(y, m)) begin
            days = days - month_days(y, m);
            m    = m + 1'b1;
            if (m > MONTHS_PER_YEAR) begin
                m = {1'b0, MON_JAN};
                y = y + 1'b1;
            end
        end
        adv.year   = y;
        adv.month  = m[MONTH_W-1:0];
        adv.day    = days[DAY_W-1:0];
        adv.hour   = HOUR_W'(hrs % HOUR_PER_DAY);
        adv.minute = MIN_W'(mins % SEC_PER_MIN);
        adv.second = SEC_W'(secs % SEC_PER_MIN);
        return adv;
    endfunction

    function automatic int draw_gap(input int n);
        return ((n / 50) % 4 == 2) ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic queue_beat(input int y, input int mo, input int d, input int h,
                              input int mi, input int s, input longint off,
                              input bit drain);
        add_beat_t b;
        b.start.year   = YEAR_W'(y);
        b.start.month  = MONTH_W'(mo);
        b.start.day    = DAY_W'(d);
        b.start.hour   = HOUR_W'(h);
        b.start.minute = MIN_W'(mi);
        b.start.second = SEC_W'(s);
        b.offset       = ADD_W'(off);
        b.gap          = draw_gap(beats_queued);
        b.drain_first  = drain;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    function automatic add_beat_t random_beat();
        add_beat_t b;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            b.start.year = YEAR_W'($urandom_range(1, 9999));
        else if (pick < 85)
            b.start.year = YEAR_W'($urandom_range(0, 16383));
        else
            b.start.year = YEAR_W'($urandom_range(16378, 16383));
        pick = $urandom_range(0, 99);
        b.start.month = (pick < 85) ? MONTH_W'($urandom_range(1, 12))
                                    : MONTH_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            b.start.day = DAY_W'($urandom_range(27, 31));
        else if (pick < 90)
            b.start.day = DAY_W'($urandom_range(1, 31));
        else
            b.start.day = DAY_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            b.start.hour   = HOUR_W'($urandom_range(0, 23));
            b.start.minute = MIN_W'($urandom_range(0, 59));
            b.start.second = SEC_W'($urandom_range(0, 59));
        end else begin
            b.start.hour   = HOUR_W'($urandom_range(0, 31));
            b.start.minute = MIN_W'($urandom_range(0, 63));
            b.start.second = SEC_W'($urandom_range(0, 63));
        end
        // long offsets cross hundreds of months and are slow, so keep them rare
        pick = $urandom_range(0, 99);
        if (pick < 10)
            b.offset = ADD_W'($urandom_range(0, 59));
        else if (pick < 45)
            b.offset = ADD_W'($urandom_range(0, 400000));
        else if (pick < 75)
            b.offset = ADD_W'($urandom_range(0, 40000000));
        else if (pick < 88)
            b.offset = ADD_W'($urandom_range(0, 400000000));
        else
            b.offset = ADD_W'($urandom() & 32'h7FFF_FFFF);
        return b;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 50)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("calendar_datetime_seconds_adder verification failed");
        $finish;
    end

    // request driver: one beat at a time, gap drawn per beat
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        if (!rst_n)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.start_year     <= '0;
            req_ch.start_month    <= '0;
            req_ch.start_day      <= '0;
            req_ch.start_hour     <= '0;
            req_ch.start_minute   <= '0;
            req_ch.start_second   <= '0;
            req_ch.seconds_to_add <= '0;
            hold_left = 0;
            gap_drawn = 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                results_due.push_back(advance_stamp(cur_beat));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (!gap_drawn && pending_beats.size() != 0)
                begin
                    hold_left = pending_beats[0].gap;
                    gap_drawn = 1'b1;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].drain_first && results_due.size() != 0))
                begin
                    cur_beat  = pending_beats.pop_front();
                    gap_drawn = 1'b0;
                    req_ch.start_year     <= cur_beat.start.year;
                    req_ch.start_month    <= cur_beat.start.month;
                    req_ch.start_day      <= cur_beat.start.day;
                    req_ch.start_hour     <= cur_beat.start.hour;
                    req_ch.start_minute   <= cur_beat.start.minute;
                    req_ch.start_second   <= cur_beat.start.second;
                    req_ch.seconds_to_add <= cur_beat.offset;
                    req_ch.valid          <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: stall cycles count only while a beat is offered
    always @(posedge clk or negedge rst_n)
    begin : take_results
        stamp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                    flag_mismatch("result beat with nothing outstanding");
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.result_year !== want.year)
                        flag_mismatch($sformatf("year got %0d want %0d",
                                                rsp_ch.result_year, want.year));
                    if (rsp_ch.result_month !== want.month)
                        flag_mismatch($sformatf("month got %0d want %0d",
                                                rsp_ch.result_month, want.month));
                    if (rsp_ch.result_day !== want.day)
                        flag_mismatch($sformatf("day got %0d want %0d",
                                                rsp_ch.result_day, want.day));
                    if (rsp_ch.result_hour !== want.hour)
                        flag_mismatch($sformatf("hour got %0d want %0d",
                                                rsp_ch.result_hour, want.hour));
                    if (rsp_ch.result_minute !== want.minute)
                        flag_mismatch($sformatf("minute got %0d want %0d",
                                                rsp_ch.result_minute, want.minute));
                    if (rsp_ch.result_second !== want.second)
                        flag_mismatch($sformatf("second got %0d want %0d",
                                                rsp_ch.result_second, want.second));
                end
                stall_left = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
            end
            else if (rsp_ch.valid && stall_left > 0)
                stall_left--;
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    initial
    begin
        add_beat_t b;
        rst_n                 = 1'b0;
        results_seen          = 0;
        mismatches            = 0;
        beats_queued          = 0;

        // directed corners
        queue_beat(2024,  1,  1,  0,  0,  0, 0, 1'b0);
        queue_beat(1,     1,  1,  0,  0,  0, 0, 1'b0);
        queue_beat(9999, 12, 31, 23, 59, 59, 1, 1'b0);
        queue_beat(9999, 12, 31, 23, 59, 59, 64'h7FFF_FFFF, 1'b0);
        queue_beat(2023,  2, 28, 23, 59, 59, 1, 1'b0);
        queue_beat(2024,  2, 28, 12,  0,  0, 86400, 1'b0);
        queue_beat(2000,  2, 28,  0,  0,  0, 86400, 1'b0);
        queue_beat(1900,  2, 28,  0,  0,  0, 86400, 1'b0);
        queue_beat(2100,  2, 28,  0,  0,  0, 86400, 1'b0);
        queue_beat(2024,  5,  0,  0,  0,  0, 0, 1'b0);
        queue_beat(2024,  4, 31,  0,  0,  0, 0, 1'b0);
        queue_beat(2024,  6, 15, 31, 63, 63, 0, 1'b0);
        queue_beat(2024,  6, 15,  0,  0, 61, 0, 1'b0);
        queue_beat(2024,  0, 30,  0,  0,  0, 0, 1'b0);
        queue_beat(2024,  0, 30,  0,  0,  0, 86400, 1'b0);
        queue_beat(2024, 13, 10,  5,  6,  7, 0, 1'b0);
        queue_beat(2024, 15, 30,  0,  0,  0, 86400, 1'b0);
        queue_beat(16383, 12, 31, 23, 59, 59, 1, 1'b0);
        queue_beat(0,     2, 28,  0,  0,  0, 86400, 1'b0);
        queue_beat(16383, 15, 31, 31, 63, 63, 64'h7FFF_FFFF, 1'b0);
        queue_beat(0,     0,  0,  0,  0,  0, 0, 1'b0);
        queue_beat(2023, 12, 31,  0,  0,  0, 31 * 86400, 1'b0);

        for (int n = 0; n < 600; n++)
        begin
            b             = random_beat();
            b.gap         = draw_gap(beats_queued);
            // hold off until the block has drained every so often
            b.drain_first = (n % 150 == 0);
            pending_beats.push_back(b);
            beats_queued++;
        end

        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);

        if (mismatches == 0)
            $display("calendar_datetime_seconds_adder verification clean");
        else
            $display("calendar_datetime_seconds_adder verification failed");
        $finish;
    end
endmodule
